// ===== hw/rtl/nbc_pkg.sv =====
`timescale 1ns / 1ps

package nbc_pkg;

    localparam int SLOT_W   = 4;
    localparam int BASES_W  = 24;
    localparam int BASE_W   = 3;
    localparam int FIELD_BASES = BASES_W / BASE_W;
    localparam int LEN_W    = 4;
    localparam int DIST_W   = 4;
    localparam int OUTCOME_W = 2;

    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(6);
    localparam logic [DIST_W-1:0] MAX_DIST  = DIST_W'(FIELD_BASES);

    localparam logic ACT_WRITE    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_ASSIGNED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NONE     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_TIE      = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_OVER     = 2'd3;

    // item travelling down the cell chain, with the running search state
    typedef struct packed {
        logic               action;
        logic [SLOT_W-1:0]  entry_slot;
        logic               entry_enable;
        logic [BASES_W-1:0] base_symbols;
        logic [DIST_W-1:0]  mismatch_limit;
        logic               found;
        logic [DIST_W-1:0]  best;
        logic [SLOT_W-1:0]  win;
        logic               tie;
        logic [DIST_W-1:0]  win_limit;
    } t_token;

endpackage

// ===== hw/rtl/nbc_if.sv =====
`timescale 1ns / 1ps

interface nbc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [nbc_pkg::SLOT_W-1:0]  entry_slot;
    logic                        entry_enable;
    logic [nbc_pkg::BASES_W-1:0] base_symbols;
    logic [nbc_pkg::DIST_W-1:0]  mismatch_limit;

    modport source (output valid, action, entry_slot, entry_enable, base_symbols,
                    mismatch_limit, input ready);
    modport sink   (input valid, action, entry_slot, entry_enable, base_symbols,
                    mismatch_limit, output ready);
endinterface

interface nbc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          assigned;
    logic [nbc_pkg::SLOT_W-1:0]    winner_slot;
    logic [nbc_pkg::DIST_W-1:0]    best_distance;
    logic [nbc_pkg::OUTCOME_W-1:0] outcome;

    modport source (output valid, assigned, winner_slot, best_distance, outcome,
                    input ready);
    modport sink   (input valid, assigned, winner_slot, best_distance, outcome,
                    output ready);
endinterface

// ===== hw/rtl/nbc_cell.sv =====
`timescale 1ns / 1ps

module nbc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [nbc_pkg::LEN_W-1:0] i_len,
    input  logic                      i_valid,
    input  nbc_pkg::t_token           i_tok,
    output logic                      o_valid,
    output nbc_pkg::t_token           o_tok
);

    localparam logic SLOT_REACHABLE = (CELL_IDX < (1 << nbc_pkg::SLOT_W));
    localparam logic [nbc_pkg::SLOT_W-1:0] MY_SLOT = nbc_pkg::SLOT_W'(CELL_IDX);

    logic                         r_entry_valid;
    logic [nbc_pkg::BASES_W-1:0]  r_bases;
    logic [nbc_pkg::DIST_W-1:0]   r_limit;
    logic                         r_valid;
    nbc_pkg::t_token              r_tok;
    nbc_pkg::t_token              n_tok;
    logic                         w_hit;
    logic [nbc_pkg::DIST_W-1:0]   w_dist;

    assign w_hit = SLOT_REACHABLE && i_valid && (i_tok.action == nbc_pkg::ACT_WRITE)
                   && (i_tok.entry_slot == MY_SLOT);

    always_comb begin
        w_dist = '0;
        for (int i = 0; i < nbc_pkg::FIELD_BASES; i++) begin
            if ((nbc_pkg::LEN_W'(i) < i_len) &&
                (i_tok.base_symbols[i*nbc_pkg::BASE_W +: nbc_pkg::BASE_W] !=
                 r_bases[i*nbc_pkg::BASE_W +: nbc_pkg::BASE_W])) begin
                w_dist = w_dist + nbc_pkg::DIST_W'(1);
            end
        end
    end

    always_comb begin
        n_tok = i_tok;
        if ((i_tok.action == nbc_pkg::ACT_CLASSIFY) && r_entry_valid) begin
            if (!i_tok.found || (w_dist < i_tok.best)) begin
                n_tok.found     = 1'b1;
                n_tok.best      = w_dist;
                n_tok.win       = MY_SLOT;
                n_tok.tie       = 1'b0;
                n_tok.win_limit = r_limit;
            end else if (w_dist == i_tok.best) begin
                n_tok.tie = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_entry_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
            if (w_hit) begin
                r_entry_valid <= i_tok.entry_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
            if (w_hit) begin
                r_bases <= i_tok.base_symbols;
                r_limit <= i_tok.mismatch_limit;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// ===== hw/rtl/nearest_barcode_classifier_unit.sv =====
`timescale 1ns / 1ps

// Barcode table as a chain of TABLE_ENTRIES cells, one cell per entry. Every item,
// write or classify, enters cell 0 and moves one cell per cycle, so one item is
// accepted each cycle; the whole chain stalls while a finished result waits in the
// output register. A classify result is registered in each cell, then in the output
// register; writes update their cell as they pass it, keeping item order. Only
// slots 0 to 15 can be written; the table is empty after reset.
module nearest_barcode_classifier_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_BASES     = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nbc_pkg::LEN_W-1:0] i_cfg_data,
    nbc_in_if.sink                    i_in,
    nbc_out_if.source                 o_res
);

    localparam int LEN_CAP = (MAX_BASES < nbc_pkg::FIELD_BASES) ? MAX_BASES
                                                                : nbc_pkg::FIELD_BASES;

    logic [nbc_pkg::LEN_W-1:0]     r_compare_length;
    logic [nbc_pkg::LEN_W-1:0]     w_eff_len;
    logic                          w_advance;
    logic                          w_vld [TABLE_ENTRIES+1];
    nbc_pkg::t_token               w_tok [TABLE_ENTRIES+1];
    logic                          r_out_valid;
    logic                          r_assigned;
    logic [nbc_pkg::SLOT_W-1:0]    r_winner;
    logic [nbc_pkg::DIST_W-1:0]    r_best;
    logic [nbc_pkg::OUTCOME_W-1:0] r_outcome;
    logic [nbc_pkg::OUTCOME_W-1:0] n_outcome;
    logic [TABLE_ENTRIES-1:0]      w_stage_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_length <= nbc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_compare_length <= i_cfg_data;
        end
    end

    assign w_eff_len = (r_compare_length > nbc_pkg::LEN_W'(LEN_CAP))
                       ? nbc_pkg::LEN_W'(LEN_CAP) : r_compare_length;

    assign w_advance = !r_out_valid || o_res.ready;
    assign i_in.ready = w_advance;

    assign w_vld[0] = i_in.valid;
    always_comb begin
        w_tok[0]                = '0;
        w_tok[0].action         = i_in.action;
        w_tok[0].entry_slot     = i_in.entry_slot;
        w_tok[0].entry_enable   = i_in.entry_enable;
        w_tok[0].base_symbols   = i_in.base_symbols;
        w_tok[0].mismatch_limit = i_in.mismatch_limit;
    end

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        nbc_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_len     (w_eff_len),
            .i_valid   (w_vld[k]),
            .i_tok     (w_tok[k]),
            .o_valid   (w_vld[k+1]),
            .o_tok     (w_tok[k+1])
        );
        assign w_stage_valid[k] = w_vld[k+1];
    end

    always_comb begin
        if (!w_tok[TABLE_ENTRIES].found) begin
            n_outcome = nbc_pkg::OUT_NONE;
        end else if (w_tok[TABLE_ENTRIES].tie) begin
            n_outcome = nbc_pkg::OUT_TIE;
        end else if (w_tok[TABLE_ENTRIES].best > w_tok[TABLE_ENTRIES].win_limit) begin
            n_outcome = nbc_pkg::OUT_OVER;
        end else begin
            n_outcome = nbc_pkg::OUT_ASSIGNED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            // writes leave the chain without a result
            r_out_valid <= w_vld[TABLE_ENTRIES]
                           && (w_tok[TABLE_ENTRIES].action == nbc_pkg::ACT_CLASSIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_outcome  <= n_outcome;
            r_assigned <= (n_outcome == nbc_pkg::OUT_ASSIGNED);
            r_winner   <= w_tok[TABLE_ENTRIES].found ? w_tok[TABLE_ENTRIES].win : '0;
            r_best     <= w_tok[TABLE_ENTRIES].found ? w_tok[TABLE_ENTRIES].best : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.assigned      = r_assigned;
    assign o_res.winner_slot   = r_winner;
    assign o_res.best_distance = r_best;
    assign o_res.outcome       = r_outcome;

    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(w_stage_valid))
        else $error("cell chain moved while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_outcome == nbc_pkg::OUT_NONE))
            |-> (r_winner == '0) && (r_best == '0) && !r_assigned)
        else $error("empty-table result carries nonzero fields");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_best <= nbc_pkg::MAX_DIST))
        else $error("mismatch count out of range");

    a_assigned_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_assigned == (r_outcome == nbc_pkg::OUT_ASSIGNED)))
        else $error("assigned flag disagrees with outcome");

endmodule

// ===== test/nearest_barcode_classifier_unit_tb.sv =====
`timescale 1ns / 1ps

localparam int TABLE_SLOTS = 16;
localparam int MAX_COMPARE = 8;
localparam int REPORT_LIMIT = 10;

typedef struct packed {
    logic                        action;
    logic [nbc_pkg::SLOT_W-1:0]  entry_slot;
    logic                        entry_enable;
    logic [nbc_pkg::BASES_W-1:0] base_symbols;
    logic [nbc_pkg::DIST_W-1:0]  mismatch_limit;
} t_barcode_item;

typedef struct packed {
    logic                          assigned;
    logic [nbc_pkg::SLOT_W-1:0]    winner_slot;
    logic [nbc_pkg::DIST_W-1:0]    best_distance;
    logic [nbc_pkg::OUTCOME_W-1:0] outcome;
} t_read_call;

class barcode_scoreboard;
    logic [nbc_pkg::BASES_W-1:0] stored_bases  [TABLE_SLOTS];
    logic [nbc_pkg::DIST_W-1:0]  stored_limits [TABLE_SLOTS];
    logic                        entry_live    [TABLE_SLOTS];
    logic [nbc_pkg::LEN_W-1:0]   compare_length;
    t_read_call                  expected_calls[$];
    int                          mismatches;

    function new();
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            stored_bases[s]  = '0;
            stored_limits[s] = '0;
            entry_live[s]    = 1'b0;
        end
        compare_length = nbc_pkg::LEN_RESET;
        mismatches     = 0;
    endfunction

    function void set_length(logic [nbc_pkg::LEN_W-1:0] value);
        compare_length = value;
    endfunction

    function int pending();
        return expected_calls.size();
    endfunction

    function t_read_call classify_read(logic [nbc_pkg::BASES_W-1:0] bases);
        t_read_call call;
        int         len;
        int         mism;
        int         best;
        int         win;
        logic       found;
        logic       tie;
        len   = (int'(compare_length) > MAX_COMPARE) ? MAX_COMPARE : int'(compare_length);
        found = 1'b0;
        tie   = 1'b0;
        best  = 0;
        win   = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (entry_live[s]) begin
                mism = 0;
                for (int i = 0; i < len; i++) begin
                    if (bases[3*i +: 3] != stored_bases[s][3*i +: 3]) mism++;
                end
                if (!found || mism < best) begin
                    found = 1'b1;
                    best  = mism;
                    win   = s;
                    tie   = 1'b0;
                end else if (mism == best) begin
                    tie = 1'b1;
                end
            end
        end
        if (!found) begin
            call.outcome = nbc_pkg::OUT_NONE;
            best = 0;
            win  = 0;
        end else if (tie) begin
            call.outcome = nbc_pkg::OUT_TIE;
        end else if (best > int'(stored_limits[win])) begin
            call.outcome = nbc_pkg::OUT_OVER;
        end else begin
            call.outcome = nbc_pkg::OUT_ASSIGNED;
        end
        call.assigned      = (call.outcome == nbc_pkg::OUT_ASSIGNED);
        call.winner_slot   = nbc_pkg::SLOT_W'(win);
        call.best_distance = nbc_pkg::DIST_W'(best);
        return call;
    endfunction

    function void note_item(t_barcode_item item);
        if (item.action == nbc_pkg::ACT_WRITE) begin
            stored_bases[item.entry_slot]  = item.base_symbols;
            stored_limits[item.entry_slot] = item.mismatch_limit;
            entry_live[item.entry_slot]    = item.entry_enable;
        end else begin
            expected_calls.push_back(classify_read(item.base_symbols));
        end
    endfunction

    function void check_call(t_read_call got);
        t_read_call want;
        if (expected_calls.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result assigned=%0d slot=%0d dist=%0d outcome=%0d",
                         $realtime, got.assigned, got.winner_slot, got.best_distance,
                         got.outcome);
            return;
        end
        want = expected_calls.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: mismatch expected assigned=%0d slot=%0d dist=%0d outcome=%0d,",
                         $realtime, want.assigned, want.winner_slot, want.best_distance,
                         want.outcome,
                         " got assigned=%0d slot=%0d dist=%0d outcome=%0d",
                         got.assigned, got.winner_slot, got.best_distance, got.outcome);
        end
    endfunction
endclass

module nearest_barcode_classifier_unit_tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 110;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [nbc_pkg::LEN_W-1:0] i_cfg_data;
    logic                      in_fast;
    logic                      out_fast;
    int                        idle_cycles;

    barcode_scoreboard sb;

    nbc_in_if  in_ch ();
    nbc_out_if res_ch ();

    nearest_barcode_classifier_unit #(
        .TABLE_ENTRIES (TABLE_SLOTS),
        .MAX_BASES     (MAX_COMPARE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_item(input t_barcode_item item);
        int gap;
        gap = in_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= item.action;
        in_ch.entry_slot     <= item.entry_slot;
        in_ch.entry_enable   <= item.entry_enable;
        in_ch.base_symbols   <= item.base_symbols;
        in_ch.mismatch_limit <= item.mismatch_limit;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(item);
    endtask

    task automatic write_entry(input int slot, input logic enable,
                               input logic [nbc_pkg::BASES_W-1:0] bases, input int limit);
        t_barcode_item item;
        item.action         = nbc_pkg::ACT_WRITE;
        item.entry_slot     = nbc_pkg::SLOT_W'(slot);
        item.entry_enable   = enable;
        item.base_symbols   = bases;
        item.mismatch_limit = nbc_pkg::DIST_W'(limit);
        send_item(item);
    endtask

    task automatic classify(input logic [nbc_pkg::BASES_W-1:0] bases);
        t_barcode_item item;
        item.action         = nbc_pkg::ACT_CLASSIFY;
        item.entry_slot     = nbc_pkg::SLOT_W'($urandom_range(0, 15));
        item.entry_enable   = 1'($urandom_range(0, 1));
        item.base_symbols   = bases;
        item.mismatch_limit = nbc_pkg::DIST_W'($urandom_range(0, 15));
        send_item(item);
    endtask

    // drain the chain before touching the register
    task automatic set_compare_length(input logic [nbc_pkg::LEN_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_length(value);
    endtask

    function automatic logic [nbc_pkg::BASES_W-1:0] mutate_bases(
        logic [nbc_pkg::BASES_W-1:0] bases, int count);
        logic [nbc_pkg::BASES_W-1:0] b;
        int                          pos;
        b = bases;
        for (int n = 0; n < count; n++) begin
            pos = $urandom_range(0, 7);
            b[3*pos +: 3] = 3'($urandom_range(0, 7));
        end
        return b;
    endfunction

    task automatic random_item();
        int pick;
        int slot;
        int limit;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, 15);
        if (pick < 25) begin
            limit = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            // copy a neighbor now and then so near ties occur
            if ($urandom_range(0, 1) == 0)
                write_entry(slot, $urandom_range(0, 4) != 0,
                            mutate_bases(sb.stored_bases[$urandom_range(0, 15)],
                                         $urandom_range(0, 2)), limit);
            else
                write_entry(slot, $urandom_range(0, 4) != 0,
                            nbc_pkg::BASES_W'($urandom), limit);
        end else if (pick < 35) begin
            classify(nbc_pkg::BASES_W'($urandom));
        end else begin
            classify(mutate_bases(sb.stored_bases[slot], $urandom_range(0, 3)));
        end
    endtask

    initial begin
        int lengths [11];
        lengths = '{1, 8, 0, 15, 9, 2, 7, 3, 5, 4, 6};
        sb = new();
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_data           <= '0;
        in_fast              <= 1'b0;
        out_fast             <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= nbc_pkg::ACT_WRITE;
        in_ch.entry_slot     <= '0;
        in_ch.entry_enable   <= 1'b0;
        in_ch.base_symbols   <= '0;
        in_ch.mismatch_limit <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, exact hit, over limit, bases past the length ignored
        classify(24'h000000);
        write_entry(0, 1'b1, 24'h000000, 0);
        classify(24'h000000);
        classify(24'hFFFFFF);
        classify(24'hFC0000);
        // large limit, closest entry, tie flagged with the lowest slot reported
        write_entry(15, 1'b1, 24'hFFFFFF, 15);
        classify(24'hFFFFFF);
        classify(24'h000FFF);
        classify(24'h0001FF);
        // disabled entry drops out, equal entries tie, disabling all empties the table
        write_entry(15, 1'b0, 24'hFFFFFF, 15);
        classify(24'hFFFFFF);
        write_entry(7, 1'b1, 24'h123456, 8);
        classify(24'h123456);
        classify(24'hEDCBA9);
        write_entry(3, 1'b1, 24'h123456, 0);
        classify(24'h123456);
        write_entry(0, 1'b0, 24'h000000, 0);
        write_entry(3, 1'b0, 24'h000000, 0);
        write_entry(7, 1'b0, 24'h000000, 0);
        classify(24'h555555);

        foreach (lengths[p]) begin
            set_compare_length(nbc_pkg::LEN_W'(lengths[p]));
            in_fast  <= ($urandom_range(0, 3) == 0);
            out_fast <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0) begin
                for (int s = 0; s < TABLE_SLOTS; s++)
                    write_entry(s, 1'b0, nbc_pkg::BASES_W'($urandom), 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: stall a random number of cycles before taking each item
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = out_fast ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_call('{assigned:      res_ch.assigned,
                            winner_slot:   res_ch.winner_slot,
                            best_distance: res_ch.best_distance,
                            outcome:       res_ch.outcome});
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
